// ----- rtl/pba_pkg.sv -----
// Package for the proximity buzzer alert: widths, register and zone codes, shared types.
package pba_pkg;

  localparam int unsigned DistanceBits = 14;
  localparam int unsigned TimeBits     = 32;
  localparam int unsigned LevelBits    = 16;
  localparam int unsigned PeriodBits   = 16;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 16;

  localparam logic [DistanceBits-1:0] NoTargetDist = DistanceBits'(9999);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_NEAR_THR    = 3'd0,
    REG_WARN_THR    = 3'd1,
    REG_CAUTION_THR = 3'd2,
    REG_FAST_PERIOD = 3'd3,
    REG_SLOW_PERIOD = 3'd4,
    REG_ON_LEVEL    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ZONE_DANGER  = 2'd0,
    ZONE_WARNING = 2'd1,
    ZONE_CAUTION = 2'd2,
    ZONE_SAFE    = 2'd3
  } zone_e;

  typedef enum logic {
    OP_ZONE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic [DistanceBits-1:0] near_thr;
    logic [DistanceBits-1:0] warn_thr;
    logic [DistanceBits-1:0] caution_thr;
    logic [PeriodBits-1:0]   fast_period;
    logic [PeriodBits-1:0]   slow_period;
  } cls_cfg_t;

  typedef struct packed {
    zone_e zone;
    logic  toggle_due;
  } cls_dec_t;

endpackage

// ----- rtl/pba_if.sv -----
// Valid/ready channel interfaces for zone/tick items and frame results.
interface pba_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [pba_pkg::DistanceBits-1:0]  distance;
  logic                              has_target;
  logic                              last_zone;

  modport source (output valid, operation, distance, has_target, last_zone, input ready);
  modport sink   (input valid, operation, distance, has_target, last_zone, output ready);
endinterface

interface pba_out_if;
  logic                              valid;
  logic                              ready;
  logic [pba_pkg::DistanceBits-1:0]  nearest_distance;
  logic [1:0]                        proximity_zone;
  logic [pba_pkg::LevelBits-1:0]     buzzer_level;
  logic                              level_changed;

  modport source (output valid, nearest_distance, proximity_zone, buzzer_level, level_changed,
                  input ready);
  modport sink   (input valid, nearest_distance, proximity_zone, buzzer_level, level_changed,
                  output ready);
endinterface

// ----- rtl/pba_classify.sv -----
// Zone classification of the frame minimum and beep period check.
module pba_classify (
  input  logic [pba_pkg::DistanceBits-1:0] nearest_i,
  input  pba_pkg::cls_cfg_t                cfg_i,
  input  logic [pba_pkg::TimeBits-1:0]     ms_count_i,
  input  logic [pba_pkg::TimeBits-1:0]     toggle_stamp_i,
  output pba_pkg::cls_dec_t                dec_o
);

  logic [pba_pkg::TimeBits-1:0]   elapsed;
  logic [pba_pkg::PeriodBits-1:0] period;
  pba_pkg::zone_e                 zone;

  assign elapsed = ms_count_i - toggle_stamp_i;

  always_comb begin
    if (nearest_i < cfg_i.near_thr) begin
      zone = pba_pkg::ZONE_DANGER;
    end else if (nearest_i < cfg_i.warn_thr) begin
      zone = pba_pkg::ZONE_WARNING;
    end else if (nearest_i < cfg_i.caution_thr) begin
      zone = pba_pkg::ZONE_CAUTION;
    end else begin
      zone = pba_pkg::ZONE_SAFE;
    end
  end

  assign period = (zone == pba_pkg::ZONE_WARNING) ? cfg_i.fast_period
                                                  : cfg_i.slow_period;

  always_comb begin
    dec_o.zone       = zone;
    dec_o.toggle_due = (elapsed >= pba_pkg::TimeBits'(period));
  end

endmodule

// ----- rtl/proximity_buzzer_alert.sv -----
// Top level of the proximity buzzer alert.
//
// in_i carries zone results and millisecond ticks (operation 1). Zones of a
// frame fold into a running minimum; the zone flagged last_zone yields one
// result on out_o: the frame minimum (9999 when no target), its zone and the
// buzzer level. Ticks and other zones give no result.
// An accepted item is held in the input register and is then worked
// in one pass into the result register: out_o.valid rises once the last
// zone has passed through the input register and the result register.
// One item per cycle is taken while in_i.ready is high; the
// only limit is the single result register, so in_i.ready drops only when a
// result waits, out_o.ready is low and the registered item needs the result
// register too. Items that give no result still drain while out_o stalls.
// Reset sets the registers to their defaults (thresholds 500/1500/2500 mm,
// periods 150/500 ms, on level 500) and clears the tick count, beep phase,
// level and running minimum (9999). Configuration is to be written only
// while no item is in flight.
module proximity_buzzer_alert (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pba_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [pba_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  pba_in_if.sink                           in_i,
  pba_out_if.source                        out_o
);

  localparam int unsigned DW = pba_pkg::DistanceBits;
  localparam int unsigned TW = pba_pkg::TimeBits;
  localparam int unsigned LW = pba_pkg::LevelBits;

  pba_pkg::cls_cfg_t  cfg_q;
  logic [LW-1:0]      on_level_q;

  logic               s1_valid_q;
  logic               s1_op_q;
  logic [DW-1:0]      s1_dist_q;
  logic               s1_has_q;
  logic               s1_last_q;

  logic [TW-1:0]      ms_q, ms_d;
  logic [TW-1:0]      toggle_stamp_q, toggle_stamp_d;
  logic               phase_q, phase_d;
  logic [DW-1:0]      min_q, min_d;
  logic [LW-1:0]      level_q, level_d;
  logic               changed;

  logic               out_valid_q;
  logic [DW-1:0]      out_dist_q;
  pba_pkg::zone_e     out_zone_q;
  logic [LW-1:0]      out_level_q;
  logic               out_changed_q;

  logic               in_fire, s1_go, s1_fire, s1_needs_out;
  logic [DW-1:0]      nearest;
  pba_pkg::cls_dec_t  dec;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_thr    <= DW'(500);
      cfg_q.warn_thr    <= DW'(1500);
      cfg_q.caution_thr <= DW'(2500);
      cfg_q.fast_period <= pba_pkg::PeriodBits'(150);
      cfg_q.slow_period <= pba_pkg::PeriodBits'(500);
      on_level_q        <= LW'(500);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pba_pkg::REG_NEAR_THR:    cfg_q.near_thr    <= cfg_wdata_i[DW-1:0];
        pba_pkg::REG_WARN_THR:    cfg_q.warn_thr    <= cfg_wdata_i[DW-1:0];
        pba_pkg::REG_CAUTION_THR: cfg_q.caution_thr <= cfg_wdata_i[DW-1:0];
        pba_pkg::REG_FAST_PERIOD: cfg_q.fast_period <= cfg_wdata_i[pba_pkg::PeriodBits-1:0];
        pba_pkg::REG_SLOW_PERIOD: cfg_q.slow_period <= cfg_wdata_i[pba_pkg::PeriodBits-1:0];
        pba_pkg::REG_ON_LEVEL:    on_level_q        <= cfg_wdata_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_needs_out = (s1_op_q == pba_pkg::OP_ZONE) && s1_last_q;
  assign s1_go        = !s1_needs_out || !out_valid_q || out_o.ready;
  assign s1_fire      = s1_valid_q && s1_go;
  assign in_i.ready   = !s1_valid_q || s1_go;
  assign in_fire      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.operation;
      s1_dist_q <= in_i.distance;
      s1_has_q  <= in_i.has_target;
      s1_last_q <= in_i.last_zone;
    end
  end

  // frame processing
  assign nearest = (s1_has_q && (s1_dist_q < min_q)) ? s1_dist_q : min_q;

  pba_classify u_classify (
    .nearest_i      (nearest),
    .cfg_i          (cfg_q),
    .ms_count_i     (ms_q),
    .toggle_stamp_i (toggle_stamp_q),
    .dec_o          (dec)
  );

  always_comb begin
    ms_d           = ms_q;
    toggle_stamp_d = toggle_stamp_q;
    phase_d        = phase_q;
    min_d          = min_q;
    level_d        = level_q;
    changed        = 1'b0;
    if (s1_fire) begin
      if (s1_op_q == pba_pkg::OP_TICK) begin
        ms_d = ms_q + TW'(1);
      end else if (!s1_last_q) begin
        min_d = nearest;
      end else begin
        min_d = pba_pkg::NoTargetDist;
        case (dec.zone)
          pba_pkg::ZONE_DANGER: begin
            level_d = on_level_q;
            changed = 1'b1;
          end
          pba_pkg::ZONE_WARNING, pba_pkg::ZONE_CAUTION: begin
            if (dec.toggle_due) begin
              phase_d        = !phase_q;
              toggle_stamp_d = ms_q;
              level_d        = phase_q ? '0 : on_level_q;
              changed        = 1'b1;
            end
          end
          default: begin
            level_d = '0;
            changed = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q           <= '0;
      toggle_stamp_q <= '0;
      phase_q        <= 1'b0;
      min_q          <= pba_pkg::NoTargetDist;
      level_q        <= '0;
    end else begin
      ms_q           <= ms_d;
      toggle_stamp_q <= toggle_stamp_d;
      phase_q        <= phase_d;
      min_q          <= min_d;
      level_q        <= level_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_needs_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_needs_out) begin
      out_dist_q    <= nearest;
      out_zone_q    <= dec.zone;
      out_level_q   <= level_d;
      out_changed_q <= changed;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.nearest_distance = out_dist_q;
  assign out_o.proximity_zone   = out_zone_q;
  assign out_o.buzzer_level     = out_level_q;
  assign out_o.level_changed    = out_changed_q;

endmodule

// ----- rtl/pba_checker.sv -----
// Port-level checker for the proximity buzzer alert, bound to the top level.
module pba_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pba_pkg::DistanceBits-1:0] nearest_distance,
  input logic [1:0]                      proximity_zone,
  input logic [pba_pkg::LevelBits-1:0]   buzzer_level,
  input logic                            level_changed
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(nearest_distance))
    else $error("result dropped or changed while stalled");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> nearest_distance <= pba_pkg::NoTargetDist)
    else $error("frame minimum above no-target value");

  // only the beeping zones may hold the level
  a_hold_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !level_changed |->
      (proximity_zone == pba_pkg::ZONE_WARNING) || (proximity_zone == pba_pkg::ZONE_CAUTION))
    else $error("level held outside warning or caution");

  a_safe_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (proximity_zone == pba_pkg::ZONE_SAFE) |-> buzzer_level == '0)
    else $error("buzzer sounding in safe zone");

endmodule

bind proximity_buzzer_alert pba_checker u_pba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .nearest_distance (out_o.nearest_distance),
  .proximity_zone   (out_o.proximity_zone),
  .buzzer_level     (out_o.buzzer_level),
  .level_changed    (out_o.level_changed)
);
